// File: rtl/core/dspm_pkg.sv
`default_nettype none

package dspm_pkg;

  // field and lane widths
  localparam int unsigned RES_W      = 30;
  localparam int unsigned WIDE_W     = 63;
  localparam int unsigned MULT_W     = 6;
  localparam int unsigned LANES      = 3;
  localparam int unsigned FOLD_STEPS = 3;

  // prime modulus and the exponents derived from it
  localparam logic [RES_W-1:0] MOD       = 30'd1000000007;
  localparam logic [RES_W-1:0] MOD_PHI   = MOD - 30'd1;
  localparam logic [RES_W-1:0] MOD_INV_E = MOD - 30'd2;

  // barrett reciprocal floor(2^60 / MOD)
  localparam logic [63:0] MU_WIDE = (64'd1 << 60) / {34'd0, MOD};
  localparam logic [30:0] MU      = MU_WIDE[30:0];

  // destination of a modular product during exponentiation
  typedef enum logic [1:0] {
    DST_ACC_A,
    DST_BASE_A,
    DST_ACC_B,
    DST_BASE_B
  } mm_dst_e;

  typedef struct packed {
    mm_dst_e dst;
    logic    wr;
  } mm_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/dspm_mulmod.sv
`default_nettype none

module dspm_mulmod import dspm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RES_W-1:0] a_i,
  input  logic [RES_W-1:0] b_i,
  input  mm_tag_t          tag_i,
  output logic             valid_o,
  output logic [RES_W-1:0] res_o,
  output mm_tag_t          tag_o
);

  localparam logic [31:0] MOD_X1 = {2'b00, MOD};
  localparam logic [31:0] MOD_X2 = {1'b0, MOD, 1'b0};

  logic [3:0]       vld_q;
  mm_tag_t          tag_q [4];
  logic [59:0]      prod1_d, prod1_q;
  logic [61:0]      q2_d, q2_q;
  logic [31:0]      plo2_q, plo3_q;
  logic [60:0]      t3_full;
  logic [31:0]      t3_q;
  logic [31:0]      rem_raw;
  logic [RES_W-1:0] res_d, res_q;

  // stage 1: full product
  assign prod1_d = 60'(a_i) * 60'(b_i);

  // stage 2: quotient estimate from the top bits
  assign q2_d = 62'(prod1_q[59:29]) * 62'(MU);

  // stage 3: estimate times modulus, low word only
  assign t3_full = 61'(q2_q[61:31]) * 61'(MOD);

  // stage 4: remainder lies below three moduli, fix it up
  assign rem_raw = plo3_q - t3_q;

  always_comb begin
    if (rem_raw >= MOD_X2) begin
      res_d = RES_W'(rem_raw - MOD_X2);
    end else if (rem_raw >= MOD_X1) begin
      res_d = RES_W'(rem_raw - MOD_X1);
    end else begin
      res_d = rem_raw[RES_W-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
    prod1_q  <= prod1_d;
    q2_q     <= q2_d;
    plo2_q   <= prod1_q[31:0];
    t3_q     <= t3_full[31:0];
    plo3_q   <= plo2_q;
    res_q    <= res_d;
  end

  assign valid_o = vld_q[3];
  assign res_o   = res_q;
  assign tag_o   = tag_q[3];

endmodule

`default_nettype wire

// File: rtl/core/dspm_fold.sv
`default_nettype none

module dspm_fold import dspm_pkg::*; (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         en_i,
  input  logic [LANES-1:0][WIDE_W-1:0] val_i,
  output logic [LANES-1:0][RES_W-1:0]  rem_o
);

  // top lane reduces by the group order, the others by the prime
  localparam logic [LANES-1:0][RES_W-1:0] LANE_MOD = {MOD_PHI, MOD, MOD};

  logic [LANES-1:0][WIDE_W-1:0] sh_d, sh_q;
  logic [LANES-1:0][RES_W-1:0]  rem_d, rem_q;
  logic [RES_W-1:0]             step_r;

  // shift one bit into the remainder, subtract once
  function automatic logic [RES_W-1:0] fold_step(input logic [RES_W-1:0] r,
                                                 input logic             b,
                                                 input logic [RES_W-1:0] m);
    logic [RES_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[RES_W-1:0];
  endfunction

  // several msb-first bits per cycle on each lane
  always_comb begin
    step_r = '0;
    for (int l = 0; l < LANES; l++) begin
      step_r = rem_q[l];
      for (int s = 0; s < FOLD_STEPS; s++) begin
        step_r = fold_step(step_r, sh_q[l][WIDE_W-1-s], LANE_MOD[l]);
      end
      rem_d[l] = step_r;
      sh_d[l]  = sh_q[l] << FOLD_STEPS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sh_q  <= val_i;
      rem_q <= '0;
    end else if (en_i) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/divisor_sum_of_power_mod_prime_top.sv
// Sum of divisors of A^B modulo 1000000007.
// Input channel (in_valid_i / in_ready_o) moves one prime factor p of A with
// its multiplicity e and a last flag per transfer. Output channel
// (out_valid_o / out_ready_i) moves the product of the per-factor geometric
// sums, one transfer for each item flagged last. B is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce. One item is handled at a time and
// in_ready_o stays low meanwhile. An item with p mod M of 2 or more goes
// through 3-bit-per-cycle folding for p mod M, B mod M, B mod (M-1) and the
// exponent, then 30 rounds on the one 4-stage modular multiplier (multiply
// and square for p^x and for (p-1)^(M-2)), then two more products. p mod M
// of 0 or 1 skips the rounds and needs only the last of those products.
// The final product is registered, then copied to the output register.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is accepted and worked on, and the block waits only
// if a new result is ready before the old one has gone.
// Reset clears B to 0, the running product to 1 and the output valid.

`default_nettype none

module divisor_sum_of_power_mod_prime_top import dspm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WIDE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WIDE_W-1:0] prime_factor_i,
  input  logic [MULT_W-1:0] multiplicity_i,
  input  logic              last_factor_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RES_W-1:0]  divisor_sum_o
);

  localparam int unsigned PROD_W = RES_W + MULT_W;
  localparam int unsigned PAD_W  = WIDE_W - PROD_W;

  localparam logic [4:0] RED1_LAST = 5'(WIDE_W / FOLD_STEPS - 1);
  localparam logic [4:0] RED2_LAST = 5'(PROD_W / FOLD_STEPS - 1);
  localparam logic [4:0] RND_LAST  = 5'(RES_W - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RED1  = 4'd1;
  localparam logic [3:0] ST_MID   = 4'd2;
  localparam logic [3:0] ST_RED2  = 4'd3;
  localparam logic [3:0] ST_SEL   = 4'd4;
  localparam logic [3:0] ST_POW   = 4'd5;
  localparam logic [3:0] ST_NUM   = 4'd6;
  localparam logic [3:0] ST_WAITG = 4'd7;
  localparam logic [3:0] ST_PROD  = 4'd8;
  localparam logic [3:0] ST_WAITP = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]              state_d, state_q;
  logic [WIDE_W-1:0]       power_b_q;
  logic                    last_d, last_q;
  logic [MULT_W-1:0]       mult_d, mult_q;
  logic [4:0]              cnt_d, cnt_q;
  logic [RES_W-1:0]        q_d, q_q;
  logic [RES_W-1:0]        g_d, g_q;
  logic [RES_W-1:0]        acc_a_d, acc_a_q, base_a_d, base_a_q;
  logic [RES_W-1:0]        acc_b_d, acc_b_q, base_b_d, base_b_q;
  logic [RES_W-1:0]        exp_a_d, exp_a_q, exp_b_d, exp_b_q;
  logic [2:0]              ph_d, ph_q;
  logic [4:0]              rnd_d, rnd_q;
  logic [RES_W-1:0]        prod_d, prod_q;
  logic                    out_load;
  logic                    out_valid_q;
  logic [RES_W-1:0]        out_data_q;

  logic                         fold_load, fold_en;
  logic [LANES-1:0][WIDE_W-1:0] fold_val;
  logic [LANES-1:0][RES_W-1:0]  fold_rem;
  logic [PROD_W-1:0]            e_bm, e_bphi;
  logic [RES_W-1:0]             t1_inc, t2_inc, s_one, x_exp, num;

  logic             mm_valid, mm_valid_o;
  logic [RES_W-1:0] mm_a, mm_b, mm_res;
  mm_tag_t          mm_tag, mm_tag_o;

  // serial reduction of wide values
  dspm_fold u_fold (
    .clk_i  (clk_i),
    .load_i (fold_load),
    .en_i   (fold_en),
    .val_i  (fold_val),
    .rem_o  (fold_rem)
  );

  // shared modular multiplier
  dspm_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm_valid),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .tag_i   (mm_tag),
    .valid_o (mm_valid_o),
    .res_o   (mm_res),
    .tag_o   (mm_tag_o)
  );

  // e times reduced B, ahead of the second fold
  assign e_bm   = PROD_W'(fold_rem[1]) * PROD_W'(mult_q);
  assign e_bphi = PROD_W'(fold_rem[2]) * PROD_W'(mult_q);

  // add one with wrap, for the q = 1 sum and the exponent
  assign t1_inc = fold_rem[1] + 30'd1;
  assign t2_inc = fold_rem[2] + 30'd1;
  assign s_one  = (t1_inc == MOD) ? '0 : t1_inc;
  assign x_exp  = (t2_inc == MOD_PHI) ? '0 : t2_inc;

  // q^x - 1 modulo the prime
  assign num = (acc_a_q == '0) ? (MOD - 30'd1) : (acc_a_q - 30'd1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    mult_d     = mult_q;
    cnt_d      = cnt_q;
    q_d        = q_q;
    g_d        = g_q;
    acc_a_d    = acc_a_q;
    base_a_d   = base_a_q;
    acc_b_d    = acc_b_q;
    base_b_d   = base_b_q;
    exp_a_d    = exp_a_q;
    exp_b_d    = exp_b_q;
    ph_d       = ph_q;
    rnd_d      = rnd_q;
    prod_d     = prod_q;
    out_load   = 1'b0;
    fold_load  = 1'b0;
    fold_en    = 1'b0;
    fold_val   = '0;
    mm_valid   = 1'b0;
    mm_a       = acc_a_q;
    mm_b       = base_a_q;
    mm_tag.dst = DST_ACC_A;
    mm_tag.wr  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fold_load   = 1'b1;
          fold_val[0] = prime_factor_i;
          fold_val[1] = power_b_q;
          fold_val[2] = power_b_q;
          mult_d      = multiplicity_i;
          last_d      = last_factor_i;
          cnt_d       = RED1_LAST;
          state_d     = ST_RED1;
        end
      end
      ST_RED1: begin
        fold_en = 1'b1;
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        q_d         = fold_rem[0];
        fold_load   = 1'b1;
        fold_val[1] = {e_bm, {PAD_W{1'b0}}};
        fold_val[2] = {e_bphi, {PAD_W{1'b0}}};
        cnt_d       = RED2_LAST;
        state_d     = ST_RED2;
      end
      ST_RED2: begin
        fold_en = 1'b1;
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (q_q == '0) begin
          g_d     = 30'd1;
          state_d = ST_PROD;
        end else if (q_q == 30'd1) begin
          g_d     = s_one;
          state_d = ST_PROD;
        end else begin
          acc_a_d  = 30'd1;
          base_a_d = q_q;
          exp_a_d  = x_exp;
          acc_b_d  = 30'd1;
          base_b_d = q_q - 30'd1;
          exp_b_d  = MOD_INV_E;
          ph_d     = '0;
          rnd_d    = '0;
          state_d  = ST_POW;
        end
      end
      ST_POW: begin
        // four products issued, then the multiplier drains before the next round
        mm_valid = !ph_q[2];
        case (ph_q[1:0])
          2'd0: begin
            mm_a       = acc_a_q;
            mm_b       = base_a_q;
            mm_tag.dst = DST_ACC_A;
            mm_tag.wr  = exp_a_q[0];
          end
          2'd1: begin
            mm_a       = base_a_q;
            mm_b       = base_a_q;
            mm_tag.dst = DST_BASE_A;
            mm_tag.wr  = 1'b1;
          end
          2'd2: begin
            mm_a       = acc_b_q;
            mm_b       = base_b_q;
            mm_tag.dst = DST_ACC_B;
            mm_tag.wr  = exp_b_q[0];
          end
          default: begin
            mm_a       = base_b_q;
            mm_b       = base_b_q;
            mm_tag.dst = DST_BASE_B;
            mm_tag.wr  = 1'b1;
          end
        endcase
        // write back finished products
        if (mm_valid_o && mm_tag_o.wr) begin
          case (mm_tag_o.dst)
            DST_ACC_A:  acc_a_d  = mm_res;
            DST_BASE_A: base_a_d = mm_res;
            DST_ACC_B:  acc_b_d  = mm_res;
            DST_BASE_B: base_b_d = mm_res;
            default:    acc_a_d  = acc_a_q;
          endcase
        end
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd7) begin
          exp_a_d = exp_a_q >> 1;
          exp_b_d = exp_b_q >> 1;
          rnd_d   = rnd_q + 5'd1;
          if (rnd_q == RND_LAST) begin
            state_d = ST_NUM;
          end
        end
      end
      ST_NUM: begin
        mm_valid = 1'b1;
        mm_a     = num;
        mm_b     = acc_b_q;
        state_d  = ST_WAITG;
      end
      ST_WAITG: begin
        if (mm_valid_o) begin
          g_d     = mm_res;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        mm_valid = 1'b1;
        mm_a     = prod_q;
        mm_b     = g_q;
        state_d  = ST_WAITP;
      end
      ST_WAITP: begin
        if (mm_valid_o) begin
          prod_d  = mm_res;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          prod_d   = 30'd1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      power_b_q   <= '0;
      prod_q      <= 30'd1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ph_q        <= '0;
      rnd_q       <= '0;
    end else begin
      state_q <= state_d;
      prod_q  <= prod_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      rnd_q   <= rnd_d;
      if (cfg_we_i) begin
        power_b_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    mult_q   <= mult_d;
    q_q      <= q_d;
    g_q      <= g_d;
    acc_a_q  <= acc_a_d;
    base_a_q <= base_a_d;
    acc_b_q  <= acc_b_d;
    base_b_q <= base_b_d;
    exp_a_q  <= exp_a_d;
    exp_b_q  <= exp_b_d;
    if (out_load) begin
      out_data_q <= prod_q;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_data_q;

endmodule

`default_nettype wire
